// ===== rtl/core/csiq_pkg.sv =====
// ----------------------------------------------------------------------------
// csiq_pkg
// Shared types and fixed-point constants of the scene index quantizer.
// ----------------------------------------------------------------------------
package csiq_pkg;

  typedef enum logic [1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_SET_BIAS = 2'd1,
    MODE_SET_CNT  = 2'd2,
    MODE_CONSUME  = 2'd3
  } mode_t;

  localparam int SCENE_MAX_DEF = 64;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // mixed position bias + gain * cv, Q.27
  localparam int P_W     = 34;
  localparam int FRAC_W  = 15;

  localparam logic signed [PROD_W-1:0] HALF_Q27 =
    {{(PROD_W-27){1'b0}}, 1'b1, 26'b0};
  localparam logic signed [P_W-1:0] ONE_Q27 =
    {{(P_W-28){1'b0}}, 1'b1, 27'b0};
  localparam logic [16:0] ONE_Q15 = 17'h08000;
  localparam logic [15:0] POS_ONE = 16'h8000;

endpackage

// ===== rtl/core/csiq_if.sv =====
// ----------------------------------------------------------------------------
// csiq_if
// Valid/ready channels of the scene index quantizer: event beats in, result
// beats out.
// ----------------------------------------------------------------------------
interface csiq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] cv;
  logic signed [15:0] gain;
  logic signed [16:0] bias_value;
  logic [6:0]         count_value;

  modport source (output valid, mode, cv, gain, bias_value, count_value,
                  input ready);
  modport sink   (input valid, mode, cv, gain, bias_value, count_value,
                  output ready);
endinterface

interface csiq_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  scene_index;
  logic [15:0] position;
  logic        tracking_cv;
  logic        flag_taken;

  modport source (output valid, scene_index, position, tracking_cv, flag_taken,
                  input ready);
  modport sink   (input valid, scene_index, position, tracking_cv, flag_taken,
                  output ready);
endinterface

// ===== rtl/core/cv_scene_index_quantizer.sv =====
// ----------------------------------------------------------------------------
// cv_scene_index_quantizer
// Maps a control voltage and gain onto a scene index with hysteresis-free
// rounding, tracks manual/cv mode and keeps a pending-change flag.
// ----------------------------------------------------------------------------
// One event beat is taken at a time; cmd.ready is high only while the
// sequencer is idle. A sample runs the tracking test, the mix, the quantize
// and the fire steps, and skips the 3 tracking-test steps when already
// tracking cv. A bias set or a count set runs the mix, quantize and fire
// steps. A consume, or a count set with the current count, goes straight to
// the done state. A count set that re-anchors the bias first runs the
// bit-serial division. The steps come from the single 34x18 signed
// multiplier, used at most once per step, and the one-bit-per-cycle
// restoring divider. A finished result sits in the output register, so the
// next event is accepted while it waits to be taken.
module cv_scene_index_quantizer
  import csiq_pkg::*;
#(
  parameter int SCENE_MAX = SCENE_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  csiq_cmd_if.sink   cmd,
  csiq_res_if.source res
);

  localparam int CW    = $clog2(SCENE_MAX + 1);
  localparam int DVD_W = CW + FRAC_W;
  localparam int DC_W  = $clog2(DVD_W + 1);
  localparam int IDX_W = PROD_W - 27;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_YLD_A = 10'b00_0000_0010,
    S_YLD_B = 10'b00_0000_0100,
    S_YLD_C = 10'b00_0000_1000,
    S_MIX_M = 10'b00_0001_0000,
    S_MIX_A = 10'b00_0010_0000,
    S_QUANT = 10'b00_0100_0000,
    S_FIRE  = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // architectural state
  logic [15:0]        bias_level;
  logic [CW-1:0]      scene_total;
  logic signed [15:0] last_cv;
  logic signed [15:0] entry_cv;
  logic signed [15:0] entry_gain;
  logic               cv_tracking;
  logic [CW-1:0]      fired_index;
  logic               change_pending;

  // per-event working registers
  mode_t              mode_r;
  logic signed [15:0] gain_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [P_W-1:0]    p;
  logic [15:0]        pos_r;
  logic               taken_r;
  logic [CW-1:0]      rem;
  logic [DVD_W-1:0]   quo;
  logic [DC_W-1:0]    div_cnt;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [16:0]        dcv;

  // event decode
  mode_t         cmd_mode;
  logic [CW-1:0] nsat;
  logic [CW-1:0] k_anchor;
  logic [16:0]   bias_clamped;

  // quantizer
  logic signed [PROD_W-1:0] s_round;
  logic [IDX_W-1:0]         idx_raw;
  logic [CW-1:0]            idx;
  logic signed [P_W-1:0]    bias_q27;

  // divider step
  logic [CW:0]      trial;
  logic             div_ge;
  logic [CW-1:0]    rem_next;
  logic [DVD_W-1:0] quo_next;

  logic cmd_fire;
  logic res_free;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_free  = !res.valid || res.ready;
  assign cmd_mode  = mode_t'(cmd.mode);

  always_comb begin
    if (32'(cmd.count_value) > 32'(SCENE_MAX)) begin
      nsat = CW'(SCENE_MAX);
    end else begin
      nsat = CW'(cmd.count_value);
    end
    k_anchor = (fired_index > nsat) ? nsat : fired_index;
    if (cmd.bias_value < 0) begin
      bias_clamped = '0;
    end else if ($unsigned(cmd.bias_value) > ONE_Q15) begin
      bias_clamped = ONE_Q15;
    end else begin
      bias_clamped = $unsigned(cmd.bias_value);
    end
  end

  assign dcv = 17'(last_cv) - 17'(entry_cv);

  always_comb begin
    case (state)
      S_YLD_A: begin
        mul_a = MUL_A_W'(entry_gain);
        mul_b = MUL_B_W'(dcv);
      end
      S_YLD_B: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = $signed(MUL_B_W'(scene_total));
      end
      S_MIX_M: begin
        mul_a = MUL_A_W'(gain_r);
        mul_b = MUL_B_W'(last_cv);
      end
      S_QUANT: begin
        mul_a = MUL_A_W'(p);
        mul_b = $signed(MUL_B_W'(scene_total));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign bias_q27 = $signed({{(P_W-28){1'b0}}, bias_level, 12'b0});

  // floor(p * n + 1/2), clipped to 0..n
  always_comb begin
    s_round = prod + HALF_Q27;
    idx_raw = s_round[PROD_W-1:27];
    if (s_round < 0) begin
      idx = '0;
    end else if (idx_raw > IDX_W'(scene_total)) begin
      idx = scene_total;
    end else begin
      idx = idx_raw[CW-1:0];
    end
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem, quo[DVD_W-1]};
    div_ge   = trial >= {1'b0, scene_total};
    rem_next = div_ge ? CW'(trial - {1'b0, scene_total}) : CW'(trial);
    quo_next = {quo[DVD_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bias_level     <= '0;
      scene_total    <= '0;
      last_cv        <= '0;
      entry_cv       <= '0;
      entry_gain     <= '0;
      cv_tracking    <= 1'b0;
      fired_index    <= '0;
      change_pending <= 1'b0;
      res.valid      <= 1'b0;
    end else begin
      if (state == S_DONE && res_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            mode_r  <= cmd_mode;
            gain_r  <= cmd.gain;
            taken_r <= 1'b0;
            pos_r   <= '0;
            case (cmd_mode)
              MODE_SAMPLE: begin
                last_cv <= cmd.cv;
                state   <= cv_tracking ? S_MIX_M : S_YLD_A;
              end
              MODE_SET_BIAS: begin
                bias_level  <= bias_clamped[15:0];
                entry_cv    <= last_cv;
                entry_gain  <= cmd.gain;
                cv_tracking <= 1'b0;
                state       <= S_MIX_M;
              end
              MODE_SET_CNT: begin
                if (nsat == scene_total) begin
                  state <= S_DONE;
                end else begin
                  scene_total <= nsat;
                  if (nsat != '0 && fired_index != '0) begin
                    rem     <= '0;
                    quo     <= {k_anchor, FRAC_W'(0)} + DVD_W'(nsat >> 1);
                    div_cnt <= DC_W'(DVD_W);
                    state   <= S_DIV;
                  end else begin
                    if (nsat == '0) begin
                      bias_level <= '0;
                    end
                    state <= S_MIX_M;
                  end
                end
              end
              default: begin
                taken_r        <= change_pending;
                change_pending <= 1'b0;
                state          <= S_DONE;
              end
            endcase
          end
        end
        S_YLD_A: begin
          prod  <= mul_p;
          state <= S_YLD_B;
        end
        S_YLD_B: begin
          prod  <= mul_p;
          state <= S_YLD_C;
        end
        S_YLD_C: begin
          // |gain_entry * dcv * n| > 1/2
          if (prod > HALF_Q27 || prod < -HALF_Q27) begin
            cv_tracking <= 1'b1;
          end
          state <= S_MIX_M;
        end
        S_DIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DC_W'(1)) begin
            bias_level <= quo_next[15:0];
            state      <= S_MIX_M;
          end
        end
        S_MIX_M: begin
          prod  <= mul_p;
          state <= S_MIX_A;
        end
        S_MIX_A: begin
          p     <= bias_q27 + $signed(prod[P_W-1:0]);
          state <= S_QUANT;
        end
        S_QUANT: begin
          prod  <= mul_p;
          state <= S_FIRE;
        end
        S_FIRE: begin
          if (idx != fired_index) begin
            fired_index    <= idx;
            change_pending <= 1'b1;
          end
          if (mode_r == MODE_SAMPLE) begin
            if (p < 0) begin
              pos_r <= '0;
            end else if (p > ONE_Q27) begin
              pos_r <= POS_ONE;
            end else begin
              pos_r <= p[27:12];
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded with the beat
  always_ff @(posedge clk) begin
    if (state == S_DONE && res_free) begin
      res.scene_index <= 7'(fired_index);
      res.position    <= pos_r;
      res.tracking_cv <= cv_tracking;
      res.flag_taken  <= taken_r;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (fired_index <= scene_total))
    else $error("fired index beyond scene count");

  a_bias_in_range: assert property (@(posedge clk) disable iff (rst)
    bias_level <= ONE_Q15[15:0])
    else $error("bias above one");

  a_pending_src: assert property (@(posedge clk) disable iff (rst)
    $rose(change_pending) |-> $past(state == S_FIRE))
    else $error("pending flag set outside index update");

  a_track_src: assert property (@(posedge clk) disable iff (rst)
    $rose(cv_tracking) |-> $past(state == S_YLD_C))
    else $error("cv tracking entered outside tracking test");

endmodule
